FILE: rtl/core/box_collision_move_checker_assert.svh
// Assertion macros for the box collision move checker.
`ifndef BOX_COLLISION_MOVE_CHECKER_ASSERT_SVH
`define BOX_COLLISION_MOVE_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define BCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("bcm check failed");

// Next-cycle implication, disabled in reset.
`define BCM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("bcm check failed");

// Next-cycle implication, active in reset.
`define BCM_ASSERT_NXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error("bcm check failed");

`endif

FILE: rtl/core/bcm_pkg.sv
// Shared types and constants of the box collision move checker.
`timescale 1ns / 1ps
`default_nettype none
package bcm_pkg;
   localparam int MAX_OBJECTS_DEF = 512;
   localparam int MAX_SHAPES_DEF  = 32;
   localparam int IDX_W  = 9;
   localparam int POS_W  = 16;
   localparam int SIZE_W = 16;
   localparam int SHP_W  = 5;
   localparam int SHAPE_WORD_W = 2 * SIZE_W;

   typedef enum logic [1:0] {
      FUNC_SHAPE  = 2'd0,
      FUNC_CREATE = 2'd1,
      FUNC_MOVE   = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BLOCKED = 2'd2;
   localparam logic [1:0] ST_UNUSED  = 2'd3;

   typedef struct packed {
      logic [SHP_W-1:0] shape;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } obj_type;
endpackage
`default_nettype wire

FILE: rtl/core/bcm_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module bcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                             wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bcm_cell.sv
// One object cell of the rotating object ring.
`timescale 1ns / 1ps
`default_nettype none
module bcm_cell (
   input  wire logic            clock,
   input  wire bcm_pkg::obj_type shift_in,
   input  wire logic            load,
   input  wire bcm_pkg::obj_type load_data,
   output bcm_pkg::obj_type      shift_out
);
   bcm_pkg::obj_type data_ff;
   bcm_pkg::obj_type data_in;

   always_comb begin
      data_in = load ? load_data : shift_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign shift_out = data_ff;
endmodule
`default_nettype wire

FILE: rtl/core/box_collision_move_checker.sv
// Define shape, full create, unused move: result in the cycle after start.
// Create: waits for the free slot on the object ring.
// Move: fetch, shape read, full ring scan, then write back unless blocked.
// One request at a time; the ring rotates one object per cycle past the head.
// Reset (synchronous): object table empty, shape table undefined until defined.
// Results are one-cycle strobes; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module box_collision_move_checker #(
   parameter int MAX_OBJECTS = bcm_pkg::MAX_OBJECTS_DEF,
   parameter int MAX_SHAPES  = bcm_pkg::MAX_SHAPES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_func,
   input  wire logic [8:0]         req_object_index,
   input  wire logic [4:0]         req_shape_index,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic signed [15:0] req_delta_x,
   input  wire logic signed [15:0] req_delta_y,
   input  wire logic [15:0]        req_box_width,
   input  wire logic [15:0]        req_box_height,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [8:0]              rsp_result_index,
   output logic signed [15:0]      rsp_result_x,
   output logic signed [15:0]      rsp_result_y
);
   localparam int OIW  = $clog2(MAX_OBJECTS);
   localparam int CW   = $clog2(MAX_OBJECTS + 1);
   localparam int SHW  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int CMPW = (CW > bcm_pkg::IDX_W) ? CW : bcm_pkg::IDX_W;
   localparam int SW   = bcm_pkg::SIZE_W;
   localparam int PW   = bcm_pkg::POS_W;

   typedef enum logic [2:0] {
      S_IDLE, S_CREATE, S_FETCH, S_MSHAPE, S_SCAN, S_DRAIN, S_WRITE
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [OIW-1:0]         phase_ff, phase_in;
   logic [OIW-1:0]         scan_ff, scan_in;
   logic                   sa_valid_ff, sa_valid_in;
   logic                   best_found_ff, best_found_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [bcm_pkg::IDX_W-1:0] oidx_ff, oidx_in;
   logic [bcm_pkg::SHP_W-1:0] sidx_ff, sidx_in;
   logic [PW-1:0]          px_ff, px_in, py_ff, py_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [PW-1:0]          old_x_ff, old_x_in, old_y_ff, old_y_in;
   logic [PW-1:0]          new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic                   mok_ff, mok_in;
   logic [SW-1:0]          mw_ff, mw_in, mh_ff, mh_in;
   logic                   sa_ok_ff, sa_ok_in;
   logic [OIW-1:0]         sa_idx_ff, sa_idx_in;
   logic [PW-1:0]          sa_x_ff, sa_x_in, sa_y_ff, sa_y_in;
   logic [OIW-1:0]         best_idx_ff, best_idx_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [bcm_pkg::IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [PW-1:0]          rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   bcm_pkg::obj_type       ring [MAX_OBJECTS];
   bcm_pkg::obj_type       head;
   bcm_pkg::obj_type       wr_data;
   logic                   wr_en;

   logic                   accept;
   logic                   shape_we;
   logic [bcm_pkg::SHAPE_WORD_W-1:0] shape_wdata, shape_rdata;
   logic                   head_shape_ok;
   logic                   head_used;
   logic [SW-1:0]          ob_w, ob_h;
   logic [PW:0]            diff_x, diff_y, abs_x, abs_y, half_x, half_y;
   logic                   hit;
   logic                   mover_live;

   assign head = ring[MAX_OBJECTS-1];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_OBJECTS; gi++) begin : g_cell
         if (gi == 0) begin : g_first
            bcm_cell u_cell (
               .clock     (clock),
               .shift_in  (head),
               .load      (wr_en),
               .load_data (wr_data),
               .shift_out (ring[gi])
            );
         end else begin : g_rest
            bcm_cell u_cell (
               .clock     (clock),
               .shift_in  (ring[gi-1]),
               .load      (1'b0),
               .load_data (wr_data),
               .shift_out (ring[gi])
            );
         end
      end
   endgenerate

   assign accept      = start && !busy;
   assign shape_we    = accept && (bcm_pkg::func_type'(req_func) == bcm_pkg::FUNC_SHAPE)
                        && (9'(req_shape_index) < 9'(MAX_SHAPES));
   assign shape_wdata = {req_box_width, req_box_height};

   bcm_ram #(
      .WIDTH (bcm_pkg::SHAPE_WORD_W),
      .DEPTH (MAX_SHAPES)
   ) u_shape_ram (
      .clock (clock),
      .we    (shape_we),
      .waddr (SHW'(req_shape_index)),
      .wdata (shape_wdata),
      .raddr (SHW'(head.shape)),
      .rdata (shape_rdata)
   );

   assign head_shape_ok = 9'(head.shape) < 9'(MAX_SHAPES);
   assign head_used     = CW'(phase_ff) < count_ff;

   // Scan stage B: other object against the mover
   always_comb begin
      ob_w   = sa_ok_ff ? shape_rdata[2*SW-1:SW] : '0;
      ob_h   = sa_ok_ff ? shape_rdata[SW-1:0] : '0;
      diff_x = {new_x_ff[PW-1], new_x_ff} - {sa_x_ff[PW-1], sa_x_ff};
      diff_y = {new_y_ff[PW-1], new_y_ff} - {sa_y_ff[PW-1], sa_y_ff};
      abs_x  = diff_x[PW] ? ((PW+1)'(0) - diff_x) : diff_x;
      abs_y  = diff_y[PW] ? ((PW+1)'(0) - diff_y) : diff_y;
      half_x = ({1'b0, mw_ff} + {1'b0, ob_w}) >> 1;
      half_y = ({1'b0, mh_ff} + {1'b0, ob_h}) >> 1;
      hit    = mover_live && sa_valid_ff && (ob_w != '0) && (ob_h != '0)
               && (abs_x < half_x) && (abs_y < half_y);
   end

   assign mover_live = (mw_ff != '0) && (mh_ff != '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      phase_in      = (phase_ff == OIW'(MAX_OBJECTS - 1)) ? '0 : phase_ff + 1'b1;
      scan_in       = scan_ff;
      sa_valid_in   = 1'b0;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      oidx_in       = oidx_ff;
      sidx_in       = sidx_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      old_x_in      = old_x_ff;
      old_y_in      = old_y_ff;
      new_x_in      = new_x_ff;
      new_y_in      = new_y_ff;
      mok_in        = mok_ff;
      mw_in         = mw_ff;
      mh_in         = mh_ff;
      sa_ok_in      = head_shape_ok;
      sa_idx_in     = phase_ff;
      sa_x_in       = head.x;
      sa_y_in       = head.y;
      wr_en         = 1'b0;
      wr_data       = head;

      if (hit && (!best_found_ff || (sa_idx_ff < best_idx_ff))) begin
         best_found_in = 1'b1;
         best_idx_in   = sa_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               oidx_in = req_object_index;
               sidx_in = req_shape_index;
               px_in   = req_pos_x;
               py_in   = req_pos_y;
               dx_in   = req_delta_x;
               dy_in   = req_delta_y;
               rsp_status_in = bcm_pkg::ST_DONE;
               rsp_idx_in    = '0;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               case (bcm_pkg::func_type'(req_func))
                  bcm_pkg::FUNC_CREATE: begin
                     if (count_ff == CW'(MAX_OBJECTS)) begin
                        rsp_status_in = bcm_pkg::ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_CREATE;
                     end
                  end
                  bcm_pkg::FUNC_MOVE: begin
                     if (CMPW'(req_object_index) >= CMPW'(count_ff)) begin
                        rsp_status_in = bcm_pkg::ST_UNUSED;
                        rsp_idx_in    = req_object_index;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CREATE: begin
            if (CW'(phase_ff) == count_ff) begin
               wr_en         = 1'b1;
               wr_data.shape = sidx_ff;
               wr_data.x     = px_ff;
               wr_data.y     = py_ff;
               count_in      = count_ff + 1'b1;
               rsp_status_in = bcm_pkg::ST_DONE;
               rsp_idx_in    = bcm_pkg::IDX_W'(count_ff);
               rsp_x_in      = px_ff;
               rsp_y_in      = py_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FETCH: begin
            if (phase_ff == OIW'(oidx_ff)) begin
               old_x_in = head.x;
               old_y_in = head.y;
               new_x_in = head.x + dx_ff;
               new_y_in = head.y + dy_ff;
               mok_in   = head_shape_ok;
               state_in = S_MSHAPE;
            end
         end
         S_MSHAPE: begin
            mw_in         = mok_ff ? shape_rdata[2*SW-1:SW] : '0;
            mh_in         = mok_ff ? shape_rdata[SW-1:0] : '0;
            best_found_in = 1'b0;
            scan_in       = '0;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            sa_valid_in = head_used && (phase_ff != OIW'(oidx_ff));
            scan_in     = scan_ff + 1'b1;
            if (scan_ff == OIW'(MAX_OBJECTS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (best_found_ff) begin
               rsp_status_in = bcm_pkg::ST_BLOCKED;
               rsp_idx_in    = bcm_pkg::IDX_W'(best_idx_ff);
               rsp_x_in      = old_x_ff;
               rsp_y_in      = old_y_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (phase_ff == OIW'(oidx_ff)) begin
               wr_en         = 1'b1;
               wr_data.x     = new_x_ff;
               wr_data.y     = new_y_ff;
               rsp_status_in = bcm_pkg::ST_DONE;
               rsp_idx_in    = oidx_ff;
               rsp_x_in      = new_x_ff;
               rsp_y_in      = new_y_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         phase_ff      <= '0;
         sa_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         sa_valid_ff   <= sa_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      oidx_ff       <= oidx_in;
      sidx_ff       <= sidx_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      old_x_ff      <= old_x_in;
      old_y_ff      <= old_y_in;
      new_x_ff      <= new_x_in;
      new_y_ff      <= new_y_in;
      mok_ff        <= mok_in;
      mw_ff         <= mw_in;
      mh_ff         <= mh_in;
      sa_ok_ff      <= sa_ok_in;
      sa_idx_ff     <= sa_idx_in;
      sa_x_ff       <= sa_x_in;
      sa_y_ff       <= sa_y_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_result_x     = rsp_x_ff;
   assign rsp_result_y     = rsp_y_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bcm_checker.sv
// Port-level checker for the box collision move checker, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "box_collision_move_checker_assert.svh"
module bcm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [8:0] rsp_result_index
);
   `BCM_ASSERT_NXT(a_accept_answered, clock, reset, start && !busy, rsp_valid || busy)
   `BCM_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `BCM_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid && !(start && !busy), !rsp_valid)
   `BCM_ASSERT_NXT_NR(a_reset_idle, clock, reset, !busy && !rsp_valid)
   `BCM_ASSERT_IMP(a_full_zero, clock, reset, rsp_valid && (rsp_status == bcm_pkg::ST_FULL), rsp_result_index == 9'd0)
endmodule

bind box_collision_move_checker bcm_checker u_bcm_checker (.*);
`default_nettype wire
